>>> hw/rtl/jsb_pkg.sv
// Shared types, codes and constants of the JSON string body scanner.
`timescale 1ns / 1ps

package jsb_pkg;

  // Encoding register codes
  localparam logic [2:0] ENC_UTF8    = 3'd0;
  localparam logic [2:0] ENC_UTF16LE = 3'd1;
  localparam logic [2:0] ENC_UTF16BE = 3'd2;
  localparam logic [2:0] ENC_UTF32LE = 3'd3;
  localparam logic [2:0] ENC_UTF32BE = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_QUOTE = 2'd1;
  localparam logic [1:0] ST_END   = 2'd2;
  localparam logic [1:0] ST_ERR   = 2'd3;

  // Queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  // UTF-8 view of one raw byte
  typedef enum logic [2:0] {
    BC_ASCII,
    BC_CONT,
    BC_LEAD2,
    BC_LEAD3,
    BC_LEAD4
  } byte_class_e;

  // One classified byte as it travels through the queue
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
    byte_class_e cls;
  } jsb_item_t;

  // Smallest legal code point for a UTF-8 sequence of the given length
  function automatic logic [31:0] utf8_min(input logic [2:0] len);
    logic [31:0] v;
    begin
      case (len)
        3'd2:    v = 32'h0000_0080;
        3'd3:    v = 32'h0000_0800;
        3'd4:    v = 32'h0001_0000;
        default: v = 32'h0000_0000;
      endcase
      return v;
    end
  endfunction

endpackage

>>> hw/rtl/jsb_if.sv
// Valid/ready channel interfaces of the JSON string body scanner.
`timescale 1ns / 1ps

interface jsb_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;
  modport source (output valid, data_byte, first_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface jsb_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        char_done;
  logic [31:0] code_point;
  modport source (output valid, status, char_done, code_point, input ready);
  modport sink   (input valid, status, char_done, code_point, output ready);
endinterface

interface jsb_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] encoding;
  modport source (output valid, encoding, input ready);
  modport sink   (input valid, encoding, output ready);
endinterface

>>> hw/rtl/json_string_body_scanner.sv
// Top level of the JSON string body scanner: front, queue and back.
//
// Usage:
//   byte_i   carries raw text bytes (data_byte, first_byte, last_byte); a
//            byte transfers when valid and ready are both high.
//   result_o returns one result per byte: status, char_done, code_point.
//   cfg_i    writes the encoding register (always ready); write it only
//            while no byte is in flight.
// Path: a transferred byte is written into the queue, then popped into the
//   output register that drives result_o. Throughput: one byte per cycle
//   while result_o.ready is high, set by the combinational decode and lex step in the back end.
// Mark the byte after the opening quote with first_byte; it clears the
//   scanner. After status quote, end or error the same status repeats,
//   with char_done low, until the next first_byte.
// Reset: encoding UTF-8, scanner cleared, queue and output empty.
// Receiver stall: the result is held, the two-entry queue fills and
//   byte_i.ready drops once it is full.
`timescale 1ns / 1ps

module json_string_body_scanner import jsb_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  jsb_cfg_if.sink      cfg_i,
  jsb_byte_if.sink     byte_i,
  jsb_result_if.source result_o
);

  jsb_item_t item_in, item_head;
  logic      push, pop, full, nempty;

  jsb_front u_front (
    .byte_i (byte_i),
    .full_i (full),
    .push_o (push),
    .item_o (item_in)
  );

  jsb_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (item_in),
    .pop_i    (pop),
    .head_o   (item_head),
    .nempty_o (nempty),
    .full_o   (full)
  );

  jsb_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_i),
    .head_i   (item_head),
    .nempty_i (nempty),
    .pop_o    (pop),
    .result_o (result_o)
  );

endmodule

>>> hw/rtl/jsb_front.sv
// Front end: accept raw bytes and classify them for the UTF-8 decoder.
`timescale 1ns / 1ps

module jsb_front import jsb_pkg::*; (
  jsb_byte_if.sink  byte_i,
  input  logic      full_i,
  output logic      push_o,
  output jsb_item_t item_o
);

  // Accept whenever the queue has room
  assign byte_i.ready = ~full_i;
  assign push_o       = byte_i.valid & ~full_i;

  // Classify the byte by its leading bits
  always_comb begin
    item_o.data_byte  = byte_i.data_byte;
    item_o.first_byte = byte_i.first_byte;
    item_o.last_byte  = byte_i.last_byte;
    if (byte_i.data_byte[7] == 1'b0) begin
      item_o.cls = BC_ASCII;
    end else if (byte_i.data_byte[6] == 1'b0) begin
      item_o.cls = BC_CONT;
    end else if (byte_i.data_byte[5] == 1'b0) begin
      item_o.cls = BC_LEAD2;
    end else if (byte_i.data_byte[4] == 1'b0) begin
      item_o.cls = BC_LEAD3;
    end else begin
      item_o.cls = BC_LEAD4;
    end
  end

endmodule

>>> hw/rtl/jsb_queue.sv
// Short queue of classified bytes between front and back.
`timescale 1ns / 1ps

module jsb_queue import jsb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  jsb_item_t item_i,
  input  logic      pop_i,
  output jsb_item_t head_o,
  output logic      nempty_o,
  output logic      full_o
);

  jsb_item_t        mem_q [QDEPTH];
  logic [QAW-1:0]   wptr_q, wptr_d;
  logic [QAW-1:0]   rptr_q, rptr_d;
  logic [QAW:0]     cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o   = (cnt_q == (QAW+1)'(QDEPTH));
  assign nempty_o = (cnt_q != '0);
  assign head_o   = mem_q[rptr_q];
  assign do_push  = push_i & ~full_o;
  assign do_pop   = pop_i & nempty_o;

  // Advance pointers and fill count
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == QAW'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == QAW'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Store the entry
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= item_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QAW+1)'(QDEPTH))
    else $error("queue count above depth");

  a_cnt_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push && !do_pop |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count did not grow on push");

  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !do_pop |=> full_o)
    else $error("full queue lost an entry without a pop");

endmodule

>>> hw/rtl/jsb_back.sv
// Back end: decode code points, check JSON string syntax, register results.
`timescale 1ns / 1ps

module jsb_back import jsb_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  jsb_cfg_if.sink        cfg_i,
  input  jsb_item_t      head_i,
  input  logic           nempty_i,
  output logic           pop_o,
  jsb_result_if.source   result_o
);

  // Lexer phases
  localparam logic [2:0] PH_TEXT = 3'd0;
  localparam logic [2:0] PH_ESC  = 3'd1;
  localparam logic [2:0] PH_HEX1 = 3'd2;
  localparam logic [2:0] PH_HEX2 = 3'd3;
  localparam logic [2:0] PH_HEX3 = 3'd4;
  localparam logic [2:0] PH_HEX4 = 3'd5;

  // Decoder outcomes
  localparam logic [1:0] DEC_WAIT = 2'd0;
  localparam logic [1:0] DEC_DONE = 2'd1;
  localparam logic [1:0] DEC_FAIL = 2'd2;

  logic [2:0]  enc_q;
  logic [2:0]  ph_q, ph_d;
  logic [1:0]  fst_q, fst_d;
  logic        fin_q, fin_d;
  logic [31:0] buf_q, buf_d;
  logic [2:0]  seen_q, seen_d;
  logic [2:0]  need_q, need_d;

  logic        ov_q;
  logic [1:0]  ost_q, st;
  logic        ochar_q, done;
  logic [31:0] ocp_q, cp;

  logic [2:0]  ph_e, seen_e, need_e, seen_inc;
  logic [1:0]  fst_e;
  logic        fin_e, little, partial_bad;
  logic [31:0] buf_e, sh8, buf6;
  logic [15:0] u_lo, u_hi;
  logic [1:0]  dec;
  logic [7:0]  b;

  // Configuration register
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enc_q <= ENC_UTF8;
    end else if (cfg_i.valid) begin
      enc_q <= cfg_i.encoding;
    end
  end

  // Take the next byte when the output register is free or being drained
  assign pop_o = nempty_i & (~ov_q | result_o.ready);

  // One scanner step
  always_comb begin
    b        = head_i.data_byte;
    ph_e     = head_i.first_byte ? PH_TEXT : ph_q;
    fst_e    = head_i.first_byte ? ST_RUN : fst_q;
    fin_e    = head_i.first_byte ? 1'b0 : fin_q;
    buf_e    = head_i.first_byte ? '0 : buf_q;
    seen_e   = head_i.first_byte ? '0 : seen_q;
    need_e   = head_i.first_byte ? '0 : need_q;
    seen_inc = seen_e + 3'd1;
    sh8      = {buf_e[23:0], b};
    buf6     = {buf_e[25:0], b[5:0]};
    little   = (enc_q == ENC_UTF16LE) || (enc_q == ENC_UTF32LE);
    u_lo     = little ? {sh8[7:0], sh8[15:8]} : sh8[15:0];
    u_hi     = little ? {sh8[23:16], sh8[31:24]} : sh8[31:16];
    dec      = DEC_FAIL;
    cp       = '0;
    buf_d    = buf_e;
    seen_d   = seen_e;
    need_d   = need_e;
    ph_d     = ph_e;
    st       = ST_RUN;
    done     = 1'b0;
    fin_d    = fin_e;
    fst_d    = fst_e;

    // Decode the byte under the selected encoding
    case (enc_q)
      ENC_UTF8: begin
        if (seen_e == 3'd0) begin
          case (head_i.cls)
            BC_ASCII: begin
              dec = DEC_DONE;
              cp  = {24'd0, b};
            end
            BC_LEAD2: begin
              dec = DEC_WAIT; need_d = 3'd2; seen_d = 3'd1;
              buf_d = {27'd0, b[4:0]};
            end
            BC_LEAD3: begin
              dec = DEC_WAIT; need_d = 3'd3; seen_d = 3'd1;
              buf_d = {28'd0, b[3:0]};
            end
            BC_LEAD4: begin
              dec = DEC_WAIT; need_d = 3'd4; seen_d = 3'd1;
              buf_d = {29'd0, b[2:0]};
            end
            default: dec = DEC_FAIL;
          endcase
        end else if (head_i.cls != BC_CONT || need_e < 3'd2 || need_e > 3'd4) begin
          dec = DEC_FAIL;
        end else if (seen_inc < need_e) begin
          dec    = DEC_WAIT;
          buf_d  = buf6;
          seen_d = seen_inc;
        end else if (buf6 < utf8_min(need_e)) begin
          dec = DEC_FAIL;
        end else begin
          dec = DEC_DONE;
          cp  = buf6;
        end
      end
      ENC_UTF16LE, ENC_UTF16BE: begin
        buf_d  = sh8;
        seen_d = seen_inc;
        if (seen_inc < 3'd2 || seen_inc == 3'd3) begin
          dec = DEC_WAIT;
        end else if (seen_inc == 3'd2) begin
          if (u_lo[15:8] inside {[8'hD8:8'hDB]}) begin
            dec    = DEC_WAIT;
            need_d = 3'd4;
          end else begin
            dec = DEC_DONE;
            cp  = {16'd0, u_lo};
          end
        end else if (!(u_lo[15:8] inside {[8'hDC:8'hDF]})) begin
          dec = DEC_FAIL;
        end else begin
          dec = DEC_DONE;
          cp  = 32'h0001_0000 + {12'd0, u_hi[9:0], 10'd0} + {22'd0, u_lo[9:0]};
        end
      end
      ENC_UTF32LE, ENC_UTF32BE: begin
        buf_d  = sh8;
        seen_d = seen_inc;
        need_d = 3'd4;
        if (seen_inc < 3'd4) begin
          dec = DEC_WAIT;
        end else begin
          dec = DEC_DONE;
          cp  = little ? {sh8[7:0], sh8[15:8], sh8[23:16], sh8[31:24]} : sh8;
        end
      end
      default: dec = DEC_FAIL;
    endcase

    // Drop the character buffer and run the lexer on a finished code point
    if (dec == DEC_FAIL) begin
      st = ST_ERR;
      buf_d = '0; seen_d = '0; need_d = '0;
    end else if (dec == DEC_DONE) begin
      done = 1'b1;
      buf_d = '0; seen_d = '0; need_d = '0;
      case (ph_e)
        PH_ESC: begin
          if (cp inside {32'h5C, 32'h2F, 32'h62, 32'h66, 32'h6E, 32'h72, 32'h74, 32'h22}) begin
            ph_d = PH_TEXT;
          end else if (cp == 32'h75) begin
            ph_d = PH_HEX1;
          end else begin
            st = ST_ERR;
          end
        end
        PH_HEX1, PH_HEX2, PH_HEX3, PH_HEX4: begin
          if (cp inside {[32'h30:32'h39], [32'h61:32'h66], [32'h41:32'h46]}) begin
            ph_d = (ph_e == PH_HEX4) ? PH_TEXT : ph_e + 3'd1;
          end else begin
            st = ST_ERR;
          end
        end
        default: begin
          ph_d = PH_TEXT;
          if (cp == 32'h5C) begin
            ph_d = PH_ESC;
          end else if (cp == 32'h22) begin
            st = ST_QUOTE;
          end else if (cp <= 32'h1F) begin
            st = ST_ERR;
          end
        end
      endcase
    end

    // End of input: an open UTF-8 sequence or surrogate pair is an error
    partial_bad = (seen_d != 3'd0) &&
                  ((enc_q == ENC_UTF8) ||
                   (((enc_q == ENC_UTF16LE) || (enc_q == ENC_UTF16BE)) && need_d == 3'd4));
    if (st == ST_RUN && head_i.last_byte) begin
      st = partial_bad ? ST_ERR : ST_END;
    end

    // Once finished, repeat the final status and hold all state
    if (fin_e) begin
      st     = fst_e;
      done   = 1'b0;
      cp     = '0;
      buf_d  = buf_e;
      seen_d = seen_e;
      need_d = need_e;
      ph_d   = ph_e;
    end else if (st != ST_RUN) begin
      fin_d = 1'b1;
      fst_d = st;
    end
  end

  // Scanner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_TEXT;
      fst_q  <= ST_RUN;
      fin_q  <= 1'b0;
      buf_q  <= '0;
      seen_q <= '0;
      need_q <= '0;
    end else if (pop_o) begin
      ph_q   <= ph_d;
      fst_q  <= fst_d;
      fin_q  <= fin_d;
      buf_q  <= buf_d;
      seen_q <= seen_d;
      need_q <= need_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (pop_o) begin
      ov_q <= 1'b1;
    end else if (result_o.ready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ost_q   <= st;
      ochar_q <= done;
      ocp_q   <= cp;
    end
  end

  assign result_o.valid      = ov_q;
  assign result_o.status     = ost_q;
  assign result_o.char_done  = ochar_q;
  assign result_o.code_point = ocp_q;

  a_fin_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |-> fst_q != ST_RUN)
    else $error("finished without a final status");

  a_cp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !ochar_q |-> ocp_q == 32'd0)
    else $error("code point set without a finished character");

  a_pop_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> ov_q)
    else $error("popped byte left no result");

endmodule
